[rtl/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stream pattern replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    localparam int PATTERN_MAX     = 8;
    localparam int REPLACEMENT_MAX = 8;
    localparam int LEN_W           = 4;
    localparam int BYTES_W         = 64;
    localparam int REP_IDX_W       = 3;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 64;

    typedef enum logic [1:0] {
        REG_PAT_LEN = 2'd0,
        REG_PAT     = 2'd1,
        REG_REP_LEN = 2'd2,
        REG_REP     = 2'd3
    } spr_reg_idx_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } spr_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_end;
        logic       out_final;
    } spr_out_t;

    typedef struct packed {
        logic [LEN_W-1:0]   pat_len;
        logic [BYTES_W-1:0] pat;
        logic [LEN_W-1:0]   rep_len;
        logic [BYTES_W-1:0] rep;
        logic               fill_clr;
    } spr_cfg_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       shift;
    } spr_cell_ctl_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] lim);
        sat_len = (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

[rtl/spr_cell.sv]
// ----------------------------------------------------------------------------
// spr_cell
// One window byte: load, shift from the right neighbor, compare to pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_cell
    import spr_pkg::*;
(
    input  wire logic          clk,
    input  wire spr_cell_ctl_t ctl,
    input  wire logic          load,
    input  wire logic [7:0]    right_char,
    input  wire logic [7:0]    pat_char,
    output logic [7:0]         cur_char,
    output logic               eq
);

    logic [7:0] char_reg;
    logic [7:0] char_next;

    assign cur_char  = load ? ctl.char_in : char_reg;
    assign eq        = (cur_char == pat_char);
    assign char_next = ctl.shift ? right_char : cur_char;

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

endmodule

`default_nettype wire

[rtl/spr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// spr_cfg_regs
// APB register file: pattern and replacement lengths and bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_cfg_regs
    import spr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output spr_cfg_t               cfg
);

    logic [LEN_W-1:0]   pat_len_reg, pat_len_next;
    logic [BYTES_W-1:0] pat_reg, pat_next;
    logic [LEN_W-1:0]   rep_len_reg, rep_len_next;
    logic [BYTES_W-1:0] rep_reg, rep_next;
    logic               len_wr;
    logic               wr;
    spr_reg_idx_t       idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = spr_reg_idx_t'(paddr[ADDR_W-1:3]);

    always_comb
    begin
        pat_len_next = pat_len_reg;
        pat_next     = pat_reg;
        rep_len_next = rep_len_reg;
        rep_next     = rep_reg;
        len_wr       = 1'b0;
        if (wr)
        begin
            case (idx)
                REG_PAT_LEN:
                begin
                    pat_len_next = sat_len(pwdata[LEN_W-1:0], LEN_W'(PATTERN_MAX));
                    len_wr       = 1'b1;
                end
                REG_PAT:     pat_next     = pwdata;
                REG_REP_LEN: rep_len_next = sat_len(pwdata[LEN_W-1:0],
                                                    LEN_W'(REPLACEMENT_MAX));
                REG_REP:     rep_next     = pwdata;
                default:     len_wr       = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PAT_LEN: prdata = DATA_W'(pat_len_reg);
            REG_PAT:     prdata = pat_reg;
            REG_REP_LEN: prdata = DATA_W'(rep_len_reg);
            REG_REP:     prdata = rep_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= '0;
            pat_reg     <= '0;
            rep_len_reg <= '0;
            rep_reg     <= '0;
        end
        else
        begin
            pat_len_reg <= pat_len_next;
            pat_reg     <= pat_next;
            rep_len_reg <= rep_len_next;
            rep_reg     <= rep_next;
        end
    end

    assign cfg.pat_len  = pat_len_reg;
    assign cfg.pat      = pat_reg;
    assign cfg.rep_len  = rep_len_reg;
    assign cfg.rep      = rep_reg;
    assign cfg.fill_clr = len_wr;

endmodule

`default_nettype wire

[rtl/stream_pattern_replacer_unit.sv]
// ----------------------------------------------------------------------------
// stream_pattern_replacer_unit
// Streaming find-and-replace over a byte stream with a window of byte cells.
// ----------------------------------------------------------------------------
//  port group   dir  handshake               word
//  in_*         in   in_valid / in_ready     spr_in_t  {in_char, in_last}
//  out_*        out  out_valid / out_ready   spr_out_t {out_char, out_end, out_final}
//  p*           in   APB, pready tied high   64-bit registers at 8*i
//
//  A byte that passes through goes to the output register; one held goes into the window.
//  A match, a replaced byte under an empty pattern or a last byte is followed
//  by its result words from the single output register that emits
//  replacement, flush and end.
//  Reset clears control state and config registers; window bytes and the output word need no clear.
//  A stalled output holds the output register; input waits on it and on
//  pending replacement, flush and end words.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_pattern_replacer_unit
    import spr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spr_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spr_out_t               out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    spr_cfg_t      cfg;
    spr_cell_ctl_t ctl;
    logic [PATTERN_MAX-1:0] load;
    logic [PATTERN_MAX-1:0] eq;
    logic [7:0]             win [PATTERN_MAX];

    logic [LEN_W-1:0]     fill_reg, fill_next;
    logic [LEN_W-1:0]     rep_left_reg, rep_left_next;
    logic [REP_IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic [LEN_W-1:0]     flush_reg, flush_next;
    logic                 term_reg, term_next;
    logic                 out_valid_reg, out_valid_next;
    spr_out_t             out_reg, out_next;

    logic             can_load, busy, accept;
    logic [LEN_W-1:0] f1, fill_after;
    logic             match, full, hit, miss, sb;
    logic [7:0]       sb_char;

    spr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_cell
        logic [7:0] right;
        if (g == PATTERN_MAX - 1)
        begin : g_end
            assign right = win[g];
        end
        else
        begin : g_mid
            assign right = win[g+1];
        end
        spr_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .load       (load[g]),
            .right_char (right),
            .pat_char   (cfg.pat[8*g +: 8]),
            .cur_char   (win[g]),
            .eq         (eq[g])
        );
    end

    assign can_load  = !out_valid_reg || out_ready;
    assign busy      = (rep_left_reg != '0) || (flush_reg != '0) || term_reg;
    assign in_ready  = !busy && can_load;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((LEN_W'(i) < cfg.pat_len) && !eq[i])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        f1      = fill_reg + 1'b1;
        full    = (cfg.pat_len != '0) && (f1 == cfg.pat_len);
        hit     = full && match;
        miss    = full && !match;
        sb      = ((cfg.pat_len == '0) && (cfg.rep_len == '0)) || miss;
        sb_char = (cfg.pat_len == '0) ? in_data.in_char : win[0];
        if (cfg.pat_len == '0)
            fill_after = fill_reg;
        else if (hit)
            fill_after = '0;
        else if (miss)
            fill_after = fill_reg;
        else
            fill_after = f1;

        ctl.char_in    = in_data.in_char;
        ctl.shift      = 1'b0;
        load           = '0;
        fill_next      = fill_reg;
        rep_left_next  = rep_left_reg;
        rep_idx_next   = rep_idx_reg;
        flush_next     = flush_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (accept)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                load[i] = (cfg.pat_len != '0) && (fill_reg == LEN_W'(i));
            end
            ctl.shift     = miss;
            fill_next     = in_data.in_last ? '0 : fill_after;
            rep_left_next = (((cfg.pat_len == '0) && (cfg.rep_len != '0)) || hit)
                            ? cfg.rep_len : '0;
            rep_idx_next  = '0;
            flush_next    = in_data.in_last ? fill_after : '0;
            term_next     = in_data.in_last;
            if (sb)
            begin
                out_valid_next     = 1'b1;
                out_next.out_char  = sb_char;
                out_next.out_end   = 1'b0;
                out_next.out_final = !in_data.in_last;
            end
        end
        else if (busy && can_load)
        begin
            out_valid_next = 1'b1;
            if (rep_left_reg != '0)
            begin
                out_next.out_char  = cfg.rep[{rep_idx_reg, 3'b000} +: 8];
                out_next.out_end   = 1'b0;
                out_next.out_final = (rep_left_reg == LEN_W'(1)) &&
                                     (flush_reg == '0) && !term_reg;
                rep_left_next      = rep_left_reg - 1'b1;
                rep_idx_next       = rep_idx_reg + 1'b1;
            end
            else if (flush_reg != '0)
            begin
                out_next.out_char  = win[0];
                out_next.out_end   = 1'b0;
                out_next.out_final = (flush_reg == LEN_W'(1)) && !term_reg;
                ctl.shift          = 1'b1;
                flush_next         = flush_reg - 1'b1;
            end
            else
            begin
                out_next.out_char  = '0;
                out_next.out_end   = 1'b1;
                out_next.out_final = 1'b1;
                term_next          = 1'b0;
            end
        end

        if (cfg.fill_clr)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rep_left_reg  <= '0;
            rep_idx_reg   <= '0;
            flush_reg     <= '0;
            term_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rep_left_reg  <= rep_left_next;
            rep_idx_reg   <= rep_idx_next;
            flush_reg     <= flush_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) || (fill_reg < cfg.pat_len))
        else $error("window fill reached pattern length");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (rep_left_reg <= LEN_W'(REPLACEMENT_MAX)) && (flush_reg < LEN_W'(PATTERN_MAX)))
        else $error("pending work count out of range");

    a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.out_end) |-> out_data.out_final)
        else $error("end word not marked final");

    a_last_sets_term: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.in_last) |=> term_reg)
        else $error("last word did not schedule an end word");

endmodule

`default_nettype wire

[sim/stream_pattern_replacer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_pattern_replacer_unit_tb
// Drives byte strings into the find-and-replace unit with random gaps and
// output stalls, predicts each output word from its own model of the
// window and the registers, and checks every accepted word in order.
// ----------------------------------------------------------------------------

module stream_pattern_replacer_unit_tb;

    import spr_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int TOTAL_WORDS  = 430;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    spr_in_t           in_data;
    logic              out_valid;
    logic              out_ready;
    spr_out_t          out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    spr_out_t    predicted_text [$];
    logic [7:0]  held_bytes [8];
    int          held_count;
    int          pat_len_r;
    logic [63:0] pat_r;
    int          rep_len_r;
    logic [63:0] rep_r;

    int   fail_count;
    int   words_sent;
    int   hold_off_cycles;
    logic quiet_in;
    logic quiet_out;

    stream_pattern_replacer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic void emit(logic [7:0] c, logic is_end);
        spr_out_t w;
        w.out_char  = c;
        w.out_end   = is_end;
        w.out_final = 1'b0;
        predicted_text.push_back(w);
    endfunction

    function automatic void emit_replacement();
        for (int i = 0; i < rep_len_r; i++)
            emit(rep_r[8*i +: 8], 1'b0);
    endfunction

    function automatic void replace_step(logic [7:0] c, logic last);
        int       n_prior;
        logic     hit;
        spr_out_t tail;
        n_prior = predicted_text.size();
        if (pat_len_r == 0)
        begin
            if (rep_len_r != 0)
                emit_replacement();
            else
                emit(c, 1'b0);
        end
        else
        begin
            held_bytes[held_count] = c;
            held_count++;
            if (held_count >= pat_len_r)
            begin
                hit = 1'b1;
                for (int i = 0; i < pat_len_r; i++)
                    if (held_bytes[i] != pat_r[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    emit_replacement();
                    held_count = 0;
                end
                else
                begin
                    emit(held_bytes[0], 1'b0);
                    for (int i = 0; i < 7; i++)
                        held_bytes[i] = held_bytes[i+1];
                    held_count--;
                end
            end
        end
        if (last)
        begin
            for (int i = 0; i < held_count; i++)
                emit(held_bytes[i], 1'b0);
            held_count = 0;
            emit(8'h00, 1'b1);
        end
        if (predicted_text.size() > n_prior)
        begin
            tail = predicted_text.pop_back();
            tail.out_final = 1'b1;
            predicted_text.push_back(tail);
        end
    endfunction

    function automatic void apply_reg(spr_reg_idx_t idx, logic [63:0] value);
        case (idx)
            REG_PAT_LEN:
            begin
                pat_len_r  = (value[3:0] > PATTERN_MAX) ? PATTERN_MAX : int'(value[3:0]);
                held_count = 0;
            end
            REG_PAT:
                pat_r = value;
            REG_REP_LEN:
                rep_len_r = (value[3:0] > REPLACEMENT_MAX) ? REPLACEMENT_MAX
                                                           : int'(value[3:0]);
            REG_REP:
                rep_r = value;
            default:
                ;
        endcase
    endfunction

    task automatic send_word(logic [7:0] c, logic last);
        int gap;
        gap = quiet_in ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.in_char = c;
        in_data.in_last = last;
        in_valid        = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        replace_step(c, last);
        words_sent++;
    endtask

    task automatic write_reg(spr_reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        apply_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drain all words, then give a silent match time to finish
    task automatic settle_block();
        @(negedge clk);
        in_valid = 1'b0;
        while (predicted_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_text(string s, logic last);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], last && (i == s.len() - 1));
    endtask

    task automatic test_reset_copy();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    task automatic test_empty_pattern();
        settle_block();
        write_reg(REG_REP_LEN, 64'd3);
        write_reg(REG_REP, 64'h0000_0000_007A_7978);
        send_text("AB", 1'b1);
    endtask

    task automatic test_match_expand();
        settle_block();
        write_reg(REG_PAT_LEN, 64'd2);
        write_reg(REG_PAT, 64'hFFFF_FFFF_FFFF_6261);
        write_reg(REG_REP_LEN, 64'd9);
        write_reg(REG_REP, 64'h0123_4567_89AB_CDEF);
        send_text("xabab", 1'b1);
        send_text("a", 1'b1);
    endtask

    task automatic test_length_saturation();
        logic [63:0] pat;
        pat = 64'h00FF_00FF_FF00_FF00;
        settle_block();
        write_reg(REG_PAT_LEN, 64'd15);
        write_reg(REG_PAT, pat);
        write_reg(REG_REP_LEN, 64'd0);
        write_reg(REG_REP, 64'd0);
        for (int i = 0; i < 8; i++)
            send_word(pat[8*i +: 8], 1'b0);
        send_word(8'h5A, 1'b1);
    endtask

    task automatic test_midstring_update();
        settle_block();
        write_reg(REG_PAT_LEN, 64'd3);
        write_reg(REG_PAT, 64'h0000_0000_0063_6261);
        write_reg(REG_REP_LEN, 64'd1);
        write_reg(REG_REP, 64'h0000_0000_0000_005A);
        send_text("ab", 1'b0);
        settle_block();
        write_reg(REG_PAT, 64'h0000_0000_0064_6362);
        send_text("cdx", 1'b0);
        settle_block();
        write_reg(REG_PAT_LEN, 64'd3);
        send_text("q", 1'b1);
    endtask

    task automatic test_backpressure();
        settle_block();
        write_reg(REG_PAT_LEN, 64'd2);
        write_reg(REG_PAT, 64'h0000_0000_0000_6261);
        write_reg(REG_REP_LEN, 64'd8);
        write_reg(REG_REP, 64'hFEDC_BA98_7654_3210);
        quiet_in = 1'b1;
        @(posedge clk);
        hold_off_cycles = 300;
        for (int i = 0; i < 15; i++)
            send_text("ab", 1'b0);
        send_text("z", 1'b1);
        quiet_in = 1'b0;
    endtask

    task automatic test_random_text();
        logic [7:0]  alpha [4];
        logic [7:0]  text [$];
        logic [63:0] pat_word;
        logic [63:0] rep_word;
        logic [3:0]  pat_len_w;
        logic [3:0]  rep_len_w;
        logic        closed;
        int          plen;
        int          phase_end;
        int          str_len;
        int          pick;
        int          cut;
        while (words_sent < TOTAL_WORDS)
        begin
            settle_block();
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: alpha = '{8'h61, 8'h62, 8'h63, 8'h00};
                1: alpha = '{8'hFF, 8'h00, 8'h80, 8'h7F};
                default:
                    for (int i = 0; i < 4; i++)
                        alpha[i] = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: pat_len_w = 4'd0;
                1: pat_len_w = 4'($urandom_range(8, 15));
                2: pat_len_w = 4'($urandom_range(5, 7));
                default: pat_len_w = 4'($urandom_range(1, 3));
            endcase
            plen = (pat_len_w > 8) ? 8 : int'(pat_len_w);
            for (int i = 0; i < 8; i++)
                pat_word[8*i +: 8] = (i < plen) ? alpha[$urandom_range(0, 3)] : 8'($urandom);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                rep_len_w = 4'd0;
            else if (pick == 1)
                rep_len_w = 4'($urandom_range(9, 15));
            else
                rep_len_w = 4'($urandom_range(1, 8));
            case ($urandom_range(0, 5))
                0: rep_word = '0;
                1: rep_word = '1;
                default: rep_word = {$urandom, $urandom};
            endcase
            write_reg(REG_PAT, pat_word);
            write_reg(REG_REP_LEN, {60'd0, rep_len_w});
            write_reg(REG_REP, rep_word);
            write_reg(REG_PAT_LEN, {60'd0, pat_len_w});

            phase_end = words_sent + $urandom_range(25, 50);
            if (phase_end > TOTAL_WORDS)
                phase_end = TOTAL_WORDS;
            while (words_sent < phase_end)
            begin
                text.delete();
                str_len = $urandom_range(1, 16);
                while (text.size() < str_len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40 && plen > 0)
                    begin
                        for (int i = 0; i < plen; i++)
                            text.push_back(pat_word[8*i +: 8]);
                    end
                    else if (pick < 55 && plen > 0)
                    begin
                        cut = $urandom_range(1, plen);
                        for (int i = 0; i < cut; i++)
                            text.push_back(pat_word[8*i +: 8]);
                    end
                    else if (pick < 90)
                        text.push_back(alpha[$urandom_range(0, 3)]);
                    else
                        text.push_back(8'($urandom));
                end
                closed = ($urandom_range(0, 9) != 0);
                for (int i = 0; i < text.size(); i++)
                    send_word(text[i], closed && (i == text.size() - 1));
            end
        end
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_off_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (!quiet_out)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : out_check
        spr_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_text.size() == 0)
            begin
                $error("unexpected word: out_char %0h out_end %0b out_final %0b",
                       out_data.out_char, out_data.out_end, out_data.out_final);
                fail_count++;
            end
            else
            begin
                want = predicted_text.pop_front();
                if (!want.out_end && out_data.out_char !== want.out_char)
                begin
                    $error("out_char: expected %0h, actual %0h",
                           want.out_char, out_data.out_char);
                    fail_count++;
                end
                if (out_data.out_end !== want.out_end)
                begin
                    $error("out_end: expected %0b, actual %0b",
                           want.out_end, out_data.out_end);
                    fail_count++;
                end
                if (out_data.out_final !== want.out_final)
                begin
                    $error("out_final: expected %0b, actual %0b",
                           want.out_final, out_data.out_final);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        hold_off_cycles = 0;
        quiet_in        = 1'b0;
        quiet_out       = 1'b0;
        fail_count      = 0;
        words_sent      = 0;
        held_count      = 0;
        pat_len_r       = 0;
        pat_r           = '0;
        rep_len_r       = 0;
        rep_r           = '0;
        for (int i = 0; i < 8; i++)
            held_bytes[i] = 8'h00;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_copy();
        test_empty_pattern();
        test_match_expand();
        test_length_saturation();
        test_midstring_update();
        test_backpressure();
        test_random_text();

        settle_block();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
